[rtl/ash_pkg.sv]
// Shared types, constants and helper functions for the archive string hash unit.
// Has no dependencies; used by every other file in rtl/.
`default_nettype none

package ash_pkg;

  localparam int unsigned TABLE_SECTIONS   = 5;
  localparam int unsigned SECTION_WORDS    = 256;
  localparam int unsigned TABLE_WORDS      = TABLE_SECTIONS * SECTION_WORDS;
  localparam int unsigned TABLE_AW         = $clog2(TABLE_WORDS);
  localparam int unsigned HASH_TYPE_W      = 3;
  localparam int unsigned NUM_HASH_TYPES_D = 5;

  localparam logic [31:0] SEED_ONE_INIT = 32'h7FED7FED;
  localparam logic [31:0] SEED_TWO_INIT = 32'hEEEEEEEE;
  localparam logic [31:0] LCG_START     = 32'h00100001;
  localparam logic [31:0] LCG_MOD       = 32'h002AAAAB;
  localparam logic [31:0] LCG_MUL       = 32'd125;
  localparam logic [31:0] LCG_ADD       = 32'd3;
  localparam logic [31:0] SEED_TWO_ADD  = 32'd3;

  typedef logic [TABLE_WORDS-1:0][31:0] key_rom_t;

  // Control from the front stage to the seed mixer.
  typedef struct packed {
    logic step;  // an item leaves the front stage this cycle
    logic eos;   // that item is the terminator
  } mix_ctl_t;

  // Fill the key table at elaboration time from the LCG sequence.
  function automatic key_rom_t build_key_rom();
    key_rom_t    rom;
    logic [31:0] s;
    logic [31:0] hi;
    rom = '0;
    s   = LCG_START;
    for (int col = 0; col < int'(SECTION_WORDS); col++) begin
      for (int sec = 0; sec < int'(TABLE_SECTIONS); sec++) begin
        s  = (s * LCG_MUL + LCG_ADD) % LCG_MOD;
        hi = {s[15:0], 16'h0000};
        s  = (s * LCG_MUL + LCG_ADD) % LCG_MOD;
        rom[sec * int'(SECTION_WORDS) + col] = hi | {16'h0000, s[15:0]};
      end
    end
    return rom;
  endfunction

  // Upper-case ASCII a-z; every other byte passes unchanged.
  function automatic logic [7:0] to_upper(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c inside {[8'h61:8'h7A]}) begin
      r = c - 8'h20;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/ash_key_rom.sv]
// Key table ROM with registered read data.
// Depends on ash_pkg for the table contents and address width.
`default_nettype none

module ash_key_rom (
  input  wire logic                        clk,
  input  wire logic                        rd_en,
  input  wire logic [ash_pkg::TABLE_AW-1:0] rd_addr,
  output logic      [31:0]                 rd_data_r
);
  import ash_pkg::*;

  localparam key_rom_t KEY_ROM = build_key_rom();

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= KEY_ROM[rd_addr];
    end
  end

endmodule

`default_nettype wire

[rtl/ash_mix.sv]
// Seed pair and the per-byte mixing step.
// Depends on ash_pkg for seed reset values and the control struct.
`default_nettype none

module ash_mix (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire ash_pkg::mix_ctl_t ctl,
  input  wire logic [7:0]        ch,
  input  wire logic [31:0]       key_word,
  output logic      [31:0]       seed_one
);
  import ash_pkg::*;

  logic [31:0] seed_one_r, seed_one_nxt;
  logic [31:0] seed_two_r, seed_two_nxt;

  always_comb begin
    seed_one_nxt = seed_one_r;
    seed_two_nxt = seed_two_r;
    if (ctl.step) begin
      if (ctl.eos) begin
        seed_one_nxt = SEED_ONE_INIT;
        seed_two_nxt = SEED_TWO_INIT;
      end else begin
        seed_one_nxt = key_word ^ (seed_one_r + seed_two_r);
        seed_two_nxt = {24'h000000, ch} + seed_one_nxt + seed_two_r
                     + {seed_two_r[26:0], 5'b00000} + SEED_TWO_ADD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_one_r <= SEED_ONE_INIT;
      seed_two_r <= SEED_TWO_INIT;
    end else begin
      seed_one_r <= seed_one_nxt;
      seed_two_r <= seed_two_nxt;
    end
  end

  assign seed_one = seed_one_r;

endmodule

`default_nettype wire

[rtl/archive_string_hash_unit.sv]
// Archive string hash unit: one name byte per request, hash out on the terminator.
// The hash of an accepted terminator passes the front stage and the result register to out_tvalid.
// Throughput: one request per cycle, set by the registered key ROM read feeding the
// seed update; it stalls only while a terminator waits behind an unaccepted hash.
// Reset (rst_n low, synchronous): seeds return to their start values, hash_type to 0,
// both pipeline stages empty. The key table is a constant ROM and needs no fill.
`default_nettype none

module archive_string_hash_unit #(
  parameter int unsigned NUM_HASH_TYPES = ash_pkg::NUM_HASH_TYPES_D
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // request stream
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [7:0]                     in_tdata,   // [7:0] char_code
  input  wire logic                           in_tlast,   // end_of_string
  // hash result stream
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic      [31:0]                    out_tdata,  // [31:0] hash_value
  // hash_type register write
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [ash_pkg::HASH_TYPE_W-1:0] cfg_data
);
  import ash_pkg::*;

  localparam logic [HASH_TYPE_W-1:0] LAST_SECTION = HASH_TYPE_W'(
    ((NUM_HASH_TYPES < TABLE_SECTIONS) ? NUM_HASH_TYPES : TABLE_SECTIONS) - 1);

  // Configuration: accepted any time; writes must only arrive while idle, which the block does not enforce.
  logic [HASH_TYPE_W-1:0] hash_type_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_type_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      hash_type_r <= cfg_data;
    end
  end

  // Clamp the section select; out-of-range values use the last section.
  logic [HASH_TYPE_W-1:0] section;
  logic [7:0]             ch_up;
  logic [TABLE_AW-1:0]    rom_addr;

  assign section  = (hash_type_r > LAST_SECTION) ? LAST_SECTION : hash_type_r;
  assign ch_up    = to_upper(in_tdata);
  assign rom_addr = TABLE_AW'({section, 8'h00}) + TABLE_AW'(ch_up);

  // Front stage: the accepted request alongside its registered ROM word.
  logic       s1_valid_r;
  logic       s1_eos_r;
  logic [7:0] s1_ch_r;
  logic       in_fire;
  logic       advance;
  logic       out_free;
  logic [31:0] key_word;
  logic [31:0] seed_one;
  mix_ctl_t    mix_ctl;

  // The result register is free if empty or being drained this cycle.
  assign out_free  = !out_tvalid || out_tready;
  // Bytes always drain; a terminator waits for room in the result register.
  assign advance   = s1_valid_r && (!s1_eos_r || out_free);
  assign in_tready = !s1_valid_r || advance;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_ch_r  <= ch_up;
      s1_eos_r <= in_tlast;
    end
  end

  ash_key_rom u_key_rom (
    .clk       (clk),
    .rd_en     (in_fire),
    .rd_addr   (rom_addr),
    .rd_data_r (key_word)
  );

  // Mixer: fold a byte into the seeds, or restart them on the terminator.
  assign mix_ctl.step = advance;
  assign mix_ctl.eos  = s1_eos_r;

  ash_mix u_mix (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (mix_ctl),
    .ch       (s1_ch_r),
    .key_word (key_word),
    .seed_one (seed_one)
  );

  // Result register: capture seed one as the terminator leaves the front stage.
  logic        out_valid_r;
  logic [31:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && s1_eos_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_eos_r) begin
      out_data_r <= seed_one;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire
